@@ hdl/mrr_pkg.sv @@
// Shared types and codes for the multicore round-robin scheduler.
// No dependencies.
package mrr_pkg;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // operation codes (s_tuser)
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_UNBLOCK = 2'd1;
    localparam logic [1:0] OP_EVENT   = 2'd2;

    // core event causes
    localparam logic [1:0] REASON_TICK  = 2'd0;
    localparam logic [1:0] REASON_BLOCK = 2'd1;
    localparam logic [1:0] REASON_EXIT  = 2'd2;

    // result error codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_FULL    = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ACTIVE_CORES = 3'd0;
    localparam logic [2:0] REG_QUANTUM0     = 3'd1;
    localparam logic [2:0] REG_QUANTUM3     = 3'd4;

    localparam int         NUM_QUANTUM       = 4;
    localparam logic [2:0] ACTIVE_CORES_RST  = 3'd4;
    localparam logic [15:0] QUANTUM_RST      = 16'd10;

    // result beat, next_pid in the lowest bits
    typedef struct packed {
        logic [1:0] error_code;
        logic [1:0] assigned_core;
        logic       next_idle;
        logic [5:0] next_pid;
    } result_t;

endpackage

@@ hdl/mrr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; read data holds while the read enable is low.
module mrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/multicore_round_robin_scheduler.sv @@
// Top level of the multicore round-robin scheduler.
// Depends on mrr_pkg and mrr_ram (ready queues and home-core table).
//
// Usage:
//   Input beats (s_*) carry one request: load a new process, unblock a
//   process, or report a tick/block/exit event on one core. Every request
//   gives exactly one result beat (m_*): the pid the core runs next or idle,
//   the core a loaded process was placed on, and an error code.
//   The user writes configuration (active cores, per-core quantum) through
//   cfg_wr_en/cfg_index/cfg_wr_data while no request is in flight; the block does not enforce this.
// Timing:
//   The accept edge reads the ready-queue memory and the home table; the
//   write-back edge, once the result register is free, modifies and writes
//   them back and loads the result register, which raises m_tvalid. A new
//   request is accepted only after the previous one has written back, set
//   by that read-then-write pass over the two memories.
// Reset:
//   All cores idle, every queue empty, every count and remaining slice zero,
//   every quantum at QUANTUM_RST, no process has a home. Memories need no
//   clearing pass; the block is ready in the cycle after reset is released.
// Back-pressure:
//   While a result waits on m_tready one more request is accepted; it holds
//   in its write-back stage until the result register frees.
module multicore_round_robin_scheduler
    import mrr_pkg::*;
#(
    parameter int CORES       = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_COUNT   = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] process_id, [7:6] core, [9:8] reason, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] next_pid, [6] next_idle, [8:7] assigned_core,
                                   // [10:9] error_code, rest zero
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wr_data
);

    localparam int CW   = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int CXW  = (CW > 2) ? CW : 2;
    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int FW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SW   = $clog2(2 * QUEUE_DEPTH);
    localparam int QDEP = CORES * QUEUE_DEPTH;
    localparam int QAW  = (QDEP > 1) ? $clog2(QDEP) : 1;
    localparam int HD   = (PID_COUNT < 64) ? PID_COUNT : 64;
    localparam int HW   = $clog2(HD);
    localparam int NW   = $clog2(2 * PID_COUNT);

    localparam logic [NW-1:0]  COUNT_MAX = NW'(2 * PID_COUNT - 1);
    localparam logic [FW-1:0]  FILL_FULL = FW'(QUEUE_DEPTH);
    localparam logic [QW-1:0]  HEAD_LAST = QW'(QUEUE_DEPTH - 1);
    localparam logic [SW-1:0]  QD_S      = SW'(QUEUE_DEPTH);
    localparam logic [QAW-1:0] QD_A      = QAW'(QUEUE_DEPTH);

    // configuration registers
    logic [2:0]  active_cores_reg;
    logic [15:0] quantum_reg [NUM_QUANTUM];

    // per-core state
    logic [QW-1:0] head_reg      [CORES];
    logic [FW-1:0] fill_reg      [CORES];
    logic [NW-1:0] count_reg     [CORES];
    logic [15:0]   rq_reg        [CORES];
    logic          run_valid_reg [CORES];
    logic [5:0]    run_pid_reg   [CORES];
    logic [HD-1:0] home_valid_reg;

    // request held for the write-back cycle
    state_t        state_reg, state_next;
    logic [1:0]    op_reg;
    logic [5:0]    pid_reg;
    logic [1:0]    core_reg;
    logic [1:0]    reason_reg;
    logic [CW-1:0] best_reg;

    logic          m_valid_reg;
    result_t       result_reg, result_next;

    // input fields
    logic [1:0] in_op, in_core, in_reason;
    logic [5:0] in_pid;
    logic       accept, exec_fire;

    assign in_op     = s_tuser[1:0];
    assign in_pid    = s_tdata[5:0];
    assign in_core   = s_tdata[7:6];
    assign in_reason = s_tdata[9:8];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);

    // ---------------- least-loaded core search ----------------
    logic [CW-1:0] best_sel;

    always_comb begin
        int            n_eff;
        logic [NW-1:0] best_cnt;
        if (active_cores_reg == 3'd0) begin
            n_eff = 1;
        end else if (int'(active_cores_reg) > CORES) begin
            n_eff = CORES;
        end else begin
            n_eff = int'(active_cores_reg);
        end
        best_sel = '0;
        best_cnt = count_reg[0];
        for (int i = 1; i < CORES; i++) begin
            if (i < n_eff && count_reg[i] < best_cnt) begin
                best_sel = CW'(i);
                best_cnt = count_reg[i];
            end
        end
    end

    // ---------------- memories ----------------
    logic [CW-1:0]  in_core_idx;
    logic [QAW-1:0] q_raddr, q_waddr;
    logic [5:0]     q_rdata, q_wdata;
    logic           q_we;
    logic [CW-1:0]  h_rdata;
    logic           h_we;

    assign in_core_idx = (int'(in_core) < CORES) ? CW'(in_core) : '0;
    assign q_raddr     = QAW'(in_core_idx) * QD_A + QAW'(head_reg[in_core_idx]);

    mrr_ram #(
        .WIDTH (6),
        .DEPTH (QDEP)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (q_we && exec_fire),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (accept),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    mrr_ram #(
        .WIDTH (CW),
        .DEPTH (HD)
    ) u_home_ram (
        .aclk  (aclk),
        .we    (h_we && exec_fire),
        .waddr (HW'(pid_reg)),
        .wdata (best_reg),
        .re    (accept),
        .raddr (HW'(in_pid)),
        .rdata (h_rdata)
    );

    // ---------------- write-back stage ----------------
    logic          pid_ok, ev_ok;
    logic [HW-1:0] pid_idx, run_idx;
    logic [CW-1:0] tc;
    logic [QW-1:0] cur_head, head_inc, enq_slot;
    logic [FW-1:0] cur_fill;
    logic [NW-1:0] cur_count;
    logic [15:0]   cur_rq, reload;
    logic          cur_runv;
    logic [5:0]    cur_runpid;
    logic [SW-1:0] slot_sum;

    logic          core_we, set_home, clear_home;
    logic [QW-1:0] head_next;
    logic [FW-1:0] fill_next;
    logic [NW-1:0] count_next;
    logic [15:0]   rq_next;
    logic          runv_next;
    logic [5:0]    runpid_next;

    assign pid_ok  = int'(pid_reg) < PID_COUNT;
    assign ev_ok   = int'(core_reg) < CORES;
    assign pid_idx = HW'(pid_reg);

    always_comb begin
        case (op_reg)
            OP_LOAD:    tc = best_reg;
            OP_UNBLOCK: tc = (int'(h_rdata) < CORES) ? h_rdata : '0;
            default:    tc = ev_ok ? CW'(core_reg) : '0;
        endcase
    end

    assign cur_head   = head_reg[tc];
    assign cur_fill   = fill_reg[tc];
    assign cur_count  = count_reg[tc];
    assign cur_rq     = rq_reg[tc];
    assign cur_runv   = run_valid_reg[tc];
    assign cur_runpid = run_pid_reg[tc];
    assign run_idx    = HW'(cur_runpid);
    assign reload     = quantum_reg[core_reg] - 16'd1;

    assign head_inc = (cur_head == HEAD_LAST) ? '0 : cur_head + QW'(1);
    assign slot_sum = SW'(cur_head) + SW'(cur_fill);
    assign enq_slot = (slot_sum >= QD_S) ? QW'(slot_sum - QD_S) : QW'(slot_sum);
    assign q_waddr  = QAW'(tc) * QD_A + QAW'(enq_slot);

    always_comb begin
        logic          r_valid;
        logic [5:0]    r_pid;
        logic [CXW-1:0] acore_x;
        core_we     = 1'b0;
        set_home    = 1'b0;
        clear_home  = 1'b0;
        q_we        = 1'b0;
        h_we        = 1'b0;
        q_wdata     = pid_reg;
        head_next   = cur_head;
        fill_next   = cur_fill;
        count_next  = cur_count;
        rq_next     = cur_rq;
        runv_next   = cur_runv;
        runpid_next = cur_runpid;
        r_valid     = cur_runv;
        r_pid       = cur_runpid;
        acore_x     = CXW'(best_reg);
        result_next = '0;

        case (op_reg)
            OP_LOAD: begin
                if (!pid_ok) begin
                    result_next.error_code = ERR_UNKNOWN;
                end else if (cur_fill >= FILL_FULL) begin
                    result_next.error_code = ERR_FULL;
                end else begin
                    q_we      = 1'b1;
                    core_we   = 1'b1;
                    fill_next = cur_fill + FW'(1);
                    result_next.assigned_core = acore_x[1:0];
                    if (!home_valid_reg[pid_idx]) begin
                        h_we     = 1'b1;
                        set_home = 1'b1;
                    end
                    if (cur_count < COUNT_MAX) begin
                        count_next = cur_count + NW'(1);
                    end
                end
            end
            OP_UNBLOCK: begin
                if (!pid_ok || !home_valid_reg[pid_idx]) begin
                    result_next.error_code = ERR_UNKNOWN;
                end else if (cur_fill >= FILL_FULL) begin
                    result_next.error_code = ERR_FULL;
                end else begin
                    q_we      = 1'b1;
                    core_we   = 1'b1;
                    fill_next = cur_fill + FW'(1);
                end
            end
            OP_EVENT: begin
                if (!ev_ok) begin
                    result_next.next_idle = 1'b1;
                end else begin
                    core_we = 1'b1;
                    if (reason_reg == REASON_BLOCK || reason_reg == REASON_EXIT) begin
                        rq_next = reload;
                        if (cur_fill != '0) begin
                            r_valid   = 1'b1;
                            r_pid     = q_rdata;
                            head_next = head_inc;
                            fill_next = cur_fill - FW'(1);
                        end else begin
                            r_valid = 1'b0;
                            r_pid   = '0;
                        end
                        if (reason_reg == REASON_EXIT) begin
                            if (cur_runv && int'(cur_runpid) < PID_COUNT) begin
                                clear_home = 1'b1;
                            end
                            if (cur_count != '0) begin
                                count_next = cur_count - NW'(1);
                            end
                        end
                    end else if (cur_rq == 16'd0 || !cur_runv) begin
                        // tick with slice expired or core idle
                        rq_next = reload;
                        if (cur_fill != '0) begin
                            r_valid   = 1'b1;
                            r_pid     = q_rdata;
                            head_next = head_inc;
                            if (cur_runv) begin
                                // requeue the preempted pid; fill stays the same
                                q_we    = 1'b1;
                                q_wdata = cur_runpid;
                            end else begin
                                fill_next = cur_fill - FW'(1);
                            end
                        end
                    end else begin
                        rq_next = cur_rq - 16'd1;
                    end
                    runv_next   = r_valid;
                    runpid_next = r_valid ? r_pid : '0;
                    result_next.next_pid  = r_valid ? r_pid : '0;
                    result_next.next_idle = !r_valid;
                end
            end
            default: ;
        endcase
    end

    // ---------------- control FSM ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= in_op;
            pid_reg    <= in_pid;
            core_reg   <= in_core;
            reason_reg <= in_reason;
            best_reg   <= best_sel;
        end
    end

    // ---------------- state update ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CORES; i++) begin
                head_reg[i]      <= '0;
                fill_reg[i]      <= '0;
                count_reg[i]     <= '0;
                rq_reg[i]        <= '0;
                run_valid_reg[i] <= 1'b0;
                run_pid_reg[i]   <= '0;
            end
            home_valid_reg <= '0;
        end else if (exec_fire) begin
            if (core_we) begin
                head_reg[tc]      <= head_next;
                fill_reg[tc]      <= fill_next;
                count_reg[tc]     <= count_next;
                rq_reg[tc]        <= rq_next;
                run_valid_reg[tc] <= runv_next;
                run_pid_reg[tc]   <= runpid_next;
            end
            if (set_home) begin
                home_valid_reg[pid_idx] <= 1'b1;
            end
            if (clear_home) begin
                home_valid_reg[run_idx] <= 1'b0;
            end
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_cores_reg <= ACTIVE_CORES_RST;
            for (int i = 0; i < NUM_QUANTUM; i++) begin
                quantum_reg[i] <= QUANTUM_RST;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_ACTIVE_CORES) begin
                active_cores_reg <= cfg_wr_data[2:0];
            end else if (cfg_index inside {[REG_QUANTUM0:REG_QUANTUM3]}) begin
                quantum_reg[2'(cfg_index - REG_QUANTUM0)] <= cfg_wr_data;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, result_reg};

endmodule

@@ dv/multicore_round_robin_scheduler_test.sv @@
// Self-checking testbench for multicore_round_robin_scheduler: directed and random requests,
// predicted decisions checked beat by beat against the result stream.
// Depends on mrr_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

import mrr_pkg::*;

class sched_scoreboard;
    localparam int         CORE_N    = 4;
    localparam int         DEPTH     = 16;
    localparam int         PIDS      = 64;
    localparam logic [6:0] COUNT_MAX = 7'd127;

    logic [2:0]  active_cores;
    logic [15:0] quantum     [CORE_N];
    logic [5:0]  ready_q     [CORE_N][DEPTH];
    logic [3:0]  q_head      [CORE_N];
    logic [4:0]  q_fill      [CORE_N];
    logic [6:0]  proc_count  [CORE_N];
    logic [15:0] slice_left  [CORE_N];
    bit          running     [CORE_N];
    logic [5:0]  running_pid [CORE_N];
    bit          has_home    [PIDS];
    logic [1:0]  home_of     [PIDS];
    result_t     decision_q  [$];

    int mismatches, checked, loads, unblocks, events, full_drops, unknown_drops, idle_picks;

    function new();
        active_cores = ACTIVE_CORES_RST;
        for (int c = 0; c < CORE_N; c++) begin
            quantum[c]     = QUANTUM_RST;
            q_head[c]      = '0;
            q_fill[c]      = '0;
            proc_count[c]  = '0;
            slice_left[c]  = '0;
            running[c]     = 1'b0;
            running_pid[c] = '0;
            for (int s = 0; s < DEPTH; s++)
                ready_q[c][s] = '0;
        end
        for (int p = 0; p < PIDS; p++) begin
            has_home[p] = 1'b0;
            home_of[p]  = '0;
        end
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] value);
        if (idx == REG_ACTIVE_CORES)
            active_cores = value[2:0];
        else if (idx <= REG_QUANTUM3)
            quantum[idx - REG_QUANTUM0] = value;
    endfunction

    function int pending();
        return decision_q.size();
    endfunction

    function bit push_ready(int c, logic [5:0] pid);
        logic [3:0] slot;
        if (q_fill[c] >= DEPTH)
            return 1'b0;
        slot = q_head[c] + q_fill[c][3:0];
        ready_q[c][slot] = pid;
        q_fill[c]++;
        return 1'b1;
    endfunction

    function logic [5:0] pop_ready(int c);
        logic [5:0] pid;
        pid = ready_q[c][q_head[c]];
        q_head[c]++;
        q_fill[c]--;
        return pid;
    endfunction

    function void predict_decision(logic [1:0] op, logic [5:0] pid, logic [1:0] core,
                                   logic [1:0] reason);
        result_t     r;
        int          n;
        int          best;
        int          c;
        logic [15:0] reload;
        bit          nv;
        logic [5:0]  np;
        r  = '0;
        c  = core;
        nv = 1'b0;
        np = '0;
        case (op)
            OP_LOAD: begin
                loads++;
                n = active_cores;
                if (n == 0) n = 1;
                if (n > CORE_N) n = CORE_N;
                best = 0;
                for (int i = 0; i < n; i++)
                    if (proc_count[i] < proc_count[best])
                        best = i;
                if (!push_ready(best, pid)) begin
                    r.error_code = ERR_FULL;
                    full_drops++;
                end else begin
                    r.assigned_core = best[1:0];
                    // a pid loaded twice keeps its first home
                    if (!has_home[pid]) begin
                        has_home[pid] = 1'b1;
                        home_of[pid]  = best[1:0];
                    end
                    if (proc_count[best] != COUNT_MAX)
                        proc_count[best]++;
                end
            end
            OP_UNBLOCK: begin
                unblocks++;
                if (!has_home[pid]) begin
                    r.error_code = ERR_UNKNOWN;
                    unknown_drops++;
                end else if (!push_ready(home_of[pid], pid)) begin
                    r.error_code = ERR_FULL;
                    full_drops++;
                end
            end
            OP_EVENT: begin
                events++;
                reload = quantum[c] - 16'd1;
                if (reason == REASON_BLOCK || reason == REASON_EXIT) begin
                    slice_left[c] = reload;
                    if (q_fill[c] != 0) begin
                        np = pop_ready(c);
                        nv = 1'b1;
                    end
                    if (reason == REASON_EXIT) begin
                        if (running[c])
                            has_home[running_pid[c]] = 1'b0;
                        if (proc_count[c] != 0)
                            proc_count[c]--;
                    end
                end else if (slice_left[c] == 0 || !running[c]) begin
                    // slice used up (or core idle): rotate if anyone waits
                    slice_left[c] = reload;
                    if (q_fill[c] != 0) begin
                        np = pop_ready(c);
                        nv = 1'b1;
                        if (running[c])
                            void'(push_ready(c, running_pid[c]));
                    end else begin
                        np = running_pid[c];
                        nv = running[c];
                    end
                end else begin
                    slice_left[c]--;
                    np = running_pid[c];
                    nv = running[c];
                end
                running[c]     = nv;
                running_pid[c] = nv ? np : '0;
                if (nv) begin
                    r.next_pid = np;
                end else begin
                    r.next_idle = 1'b1;
                    idle_picks++;
                end
            end
            default: ;
        endcase
        decision_q.insert(decision_q.size(), r);
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 50)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [15:0] beat);
        result_t got;
        result_t want;
        got = result_t'(beat[10:0]);
        if (decision_q.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing expected", beat));
            return;
        end
        want = decision_q.pop_front();
        checked++;
        if (got.next_pid != want.next_pid)
            report_mismatch($sformatf("beat %0d next_pid %0d, want %0d",
                                      checked, got.next_pid, want.next_pid));
        if (got.next_idle != want.next_idle)
            report_mismatch($sformatf("beat %0d next_idle %0b, want %0b",
                                      checked, got.next_idle, want.next_idle));
        if (got.assigned_core != want.assigned_core)
            report_mismatch($sformatf("beat %0d assigned_core %0d, want %0d",
                                      checked, got.assigned_core, want.assigned_core));
        if (got.error_code != want.error_code)
            report_mismatch($sformatf("beat %0d error_code %0d, want %0d",
                                      checked, got.error_code, want.error_code));
        if (beat[15:11] != '0)
            report_mismatch($sformatf("beat %0d padding bits %b", checked, beat[15:11]));
    endtask
endclass

module multicore_round_robin_scheduler_test;
    import mrr_pkg::*;

    localparam logic [1:0] OP_NONE        = 2'd3;
    localparam logic [1:0] REASON_SPARE   = 2'd3;
    localparam int         HALF_PERIOD    = 4;
    localparam int         RESET_CYCLES   = 9;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         TAIL_CYCLES    = 8;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         PHASE_ITEMS    = 130;
    localparam int         FILL_PAIRS     = 135;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [15:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tready    = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_index   = '0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;

    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    int          watchdog_count = 0;
    int          sent = 0;
    int          settings_applied = 0;
    logic [2:0]  cur_active = ACTIVE_CORES_RST;
    sched_scoreboard sb;

    multicore_round_robin_scheduler i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            watchdog_count <= 0;
        else
            watchdog_count <= watchdog_count + 1;
        if (watchdog_count >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // hold: wait for every outstanding decision before offering this beat
    task automatic send_request(input logic [1:0] op, input logic [5:0] pid,
                                input logic [1:0] core, input logic [1:0] reason,
                                input bit hold);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct && gap < 20)
            gap++;
        if ((hold && sb.pending() != 0) || gap > 0) begin
            s_tvalid <= 1'b0;
            while (hold && sb.pending() != 0)
                @(posedge aclk);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, reason, core, pid};
        do @(posedge aclk); while (!s_tready);
        sb.predict_decision(op, pid, core, reason);
        sent++;
    endtask

    task automatic apply_setting(input logic [2:0] active, input logic [15:0] q0,
                                 input logic [15:0] q1, input logic [15:0] q2,
                                 input logic [15:0] q3);
        logic [15:0] values [5];
        logic [2:0]  idx;
        values = '{{13'd0, active}, q0, q1, q2, q3};
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        for (int i = 0; i < 5; i++) begin
            idx = (i == 0) ? REG_ACTIVE_CORES : REG_QUANTUM0 + 3'(i - 1);
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx;
            cfg_wr_data <= values[i];
            @(posedge aclk);
            sb.write_reg(idx, values[i]);
        end
        cfg_wr_en <= 1'b0;
        cur_active = active;
        settings_applied++;
    endtask

    task automatic random_request(input int pool);
        logic [1:0] op;
        logic [1:0] core;
        logic [1:0] reason;
        logic [5:0] pid;
        int         pick;
        int         eff;
        int         r;
        eff  = (cur_active == 0) ? 1 : ((cur_active > 4) ? 4 : int'(cur_active));
        pick = $urandom_range(0, 99);
        pid  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, pool - 1));
        core = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                           : 2'($urandom_range(0, eff - 1));
        r = $urandom_range(0, 9);
        reason = (r < 5) ? REASON_TICK : (r < 7) ? REASON_BLOCK :
                 (r < 9) ? REASON_EXIT : REASON_SPARE;
        op = (pick < 30) ? OP_LOAD : (pick < 55) ? OP_UNBLOCK :
             (pick < 96) ? OP_EVENT : OP_NONE;
        send_request(op, pid, core, reason, $urandom_range(0, 99) == 0);
    endtask

    task automatic run_phase(input logic [2:0] active, input logic [15:0] q0,
                             input logic [15:0] q1, input logic [15:0] q2,
                             input logic [15:0] q3, input int pool,
                             input int src_pct, input int snk_pct);
        apply_setting(active, q0, q1, q2, q3);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        repeat (PHASE_ITEMS) random_request(pool);
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, reset configuration
        src_idle_pct  = 26;
        snk_stall_pct = 51;
        send_request(OP_EVENT,   6'd0,  2'd0, REASON_TICK,  1'b0);  // idle core, empty queue
        send_request(OP_LOAD,    6'd0,  2'd0, REASON_TICK,  1'b0);
        send_request(OP_LOAD,    6'd63, 2'd3, REASON_SPARE, 1'b0);
        send_request(OP_LOAD,    6'd42, 2'd0, REASON_TICK,  1'b0);
        send_request(OP_LOAD,    6'd21, 2'd0, REASON_TICK,  1'b0);
        send_request(OP_LOAD,    6'd0,  2'd0, REASON_TICK,  1'b0);  // second load, same pid
        send_request(OP_EVENT,   6'd0,  2'd0, REASON_TICK,  1'b0);
        send_request(OP_EVENT,   6'd0,  2'd0, REASON_TICK,  1'b0);
        send_request(OP_EVENT,   6'd0,  2'd1, REASON_SPARE, 1'b0);  // spare reason acts as tick
        send_request(OP_EVENT,   6'd0,  2'd2, REASON_BLOCK, 1'b0);
        send_request(OP_EVENT,   6'd0,  2'd2, REASON_EXIT,  1'b0);
        send_request(OP_UNBLOCK, 6'd42, 2'd0, REASON_TICK,  1'b0);  // home dropped on exit
        send_request(OP_EVENT,   6'd0,  2'd3, REASON_EXIT,  1'b1);  // exit on an idle core
        send_request(OP_NONE,    6'd63, 2'd3, REASON_SPARE, 1'b0);
        send_request(OP_UNBLOCK, 6'd63, 2'd0, REASON_TICK,  1'b0);
        // core 0 queue holds one entry: fill it, then overflow
        repeat (16) send_request(OP_UNBLOCK, 6'd0, 2'd0, REASON_TICK, 1'b0);

        run_phase(3'd1, 16'd1, 16'd65535, 16'd3, 16'd2, 8, 26, 51);
        run_phase(3'd0, 16'd0, 16'd2, 16'd1, 16'd5, 12, 26, 51);
        run_phase(3'd7, 16'd3, 16'd0, 16'd65535, 16'd1, 16, 26, 51);
        run_phase(3'd2, 16'd2, 16'd2, 16'd2, 16'd2, 8, 51, 26);
        run_phase(3'd3, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                  16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)), 16, 51, 26);
        run_phase(3'd4, 16'd1, 16'd1, 16'd1, 16'd1, 24, 51, 26);
        run_phase(3'd5, 16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                  16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)), 64, 0, 0);
        run_phase(3'd6, 16'd65535, 16'd1, 16'd4, 16'd0, 8, 0, 0);

        // load then block on one core until its process count saturates
        apply_setting(3'd1, 16'd2, 16'd2, 16'd2, 16'd2);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (FILL_PAIRS) begin
            send_request(OP_LOAD, 6'($urandom_range(0, 63)), 2'd0, REASON_TICK, 1'b0);
            send_request(OP_EVENT, 6'd0, 2'd0, REASON_BLOCK, 1'b0);
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d requests (%0d loads, %0d unblocks, %0d core events) over %0d settings",
                 sent, sb.loads, sb.unblocks, sb.events, settings_applied + 1);
        $display("%0d decisions checked: %0d queue-full drops, %0d unknown pids, %0d idle, %s",
                 sb.checked, sb.full_drops, sb.unknown_drops, sb.idle_picks,
                 $sformatf("%0d mismatches", sb.mismatches));
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/mrr_pkg.sv
hdl/mrr_ram.sv
hdl/multicore_round_robin_scheduler.sv
dv/multicore_round_robin_scheduler_test.sv
